// ----- rtl/rcdt_pkg.sv -----
// Shared types and constants for the clock drift timestamper.
// No dependencies; every other file in rtl/ except rcdt_mul imports this package.
package rcdt_pkg;

  typedef struct packed {
    logic [31:0] packet_count_rel;
    logic [63:0] arrival_us;
  } in_item_t;

  typedef struct packed {
    logic [63:0] stamp_us;
    logic [31:0] lost_packets;
    logic [1:0]  clamp_kind;
    logic [1:0]  fit_status;
  } out_item_t;

  // Products run on the shared multiplier, in issue order.
  typedef enum logic [3:0] {
    OP_XX, OP_DEN, OP_NUMG, OP_TX, OP_DELTA, OP_R5, OP_B, OP_C, OP_ANC, OP_PRED
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_go;
    mul_op_t op;
    logic    mul_cap;
    logic    div_go;
    logic    div_cap;
    logic    reject;
    logic    stamp;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic need_chk;
    logic fit_ok;
  } dp_stat_t;

  localparam logic [2:0] CFG_RATE     = 3'd0;
  localparam logic [2:0] CFG_PERIOD   = 3'd1;
  localparam logic [2:0] CFG_FORGET   = 3'd2;
  localparam logic [2:0] CFG_WARMUP   = 3'd3;
  localparam logic [2:0] CFG_REANCHOR = 3'd4;
  localparam logic [2:0] CFG_START    = 3'd5;
  localparam logic [2:0] CFG_MAX_LAG  = 3'd6;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_ARR  = 2'd1;
  localparam logic [1:0] CLAMP_LAG  = 2'd2;

  localparam logic [1:0] FIT_WARM   = 2'd0;
  localparam logic [1:0] FIT_ACC    = 2'd1;
  localparam logic [1:0] FIT_COMMIT = 2'd2;
  localparam logic [1:0] FIT_REJECT = 2'd3;

  localparam logic [19:0] RST_RATE     = 20'd1000;
  localparam logic [59:0] RST_PERIOD   = 60'd1099511627776000;
  localparam logic [31:0] RST_FORGET   = 32'd4294895718;
  localparam logic [31:0] RST_WARMUP   = 32'd10000;
  localparam logic [31:0] RST_REANCHOR = 32'd10000;
  localparam logic [63:0] RST_START    = 64'd0;
  localparam logic [31:0] RST_MAX_LAG  = 32'd5000;

  localparam logic [63:0]  ONE_Q62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0]  SCALE_1E5 = 64'd100000;
  // 1e11 * 2^40: left side of the exact plausibility test
  localparam logic [127:0] PLAUS_A   = 128'd100000000000 << 40;
  localparam logic [127:0] RND_Q16   = 128'd1 << 23;
  localparam logic [127:0] RND_US    = 128'd1 << 39;
  localparam logic [7:0]   DIV_STEPS = 8'd190;

endpackage

// ----- rtl/rcdt_mul.sv -----
// Multi-cycle 64x64 unsigned multiplier built on one 32x32 multiplier.
// Does not use rcdt_pkg; no submodules.
module rcdt_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  logic [63:0]  a_r, b_r;
  logic [2:0]   cnt;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [1:0]   k, pk, shsel;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp_next;
  logic [127:0] pp_shifted;

  always_comb begin
    k       = 2'(cnt - 3'd1);
    pk      = 2'(cnt - 3'd2);
    op_a    = k[1] ? a_r[63:32] : a_r[31:0];
    op_b    = k[0] ? b_r[63:32] : b_r[31:0];
    pp_next = op_a * op_b;
    shsel   = {1'b0, pk[1]} + {1'b0, pk[0]};
    case (shsel)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  // cnt 1..4 forms partial products, 2..5 accumulates the previous one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r <= a;
        b_r <= b;
        acc <= 128'd0;
        cnt <= 3'd1;
      end else if (cnt != 3'd0) begin
        if (cnt <= 3'd4) pp <= pp_next;
        if (cnt >= 3'd2) acc <= acc + pp_shifted;
        if (cnt == 3'd5) begin
          cnt  <= 3'd0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ----- rtl/rcdt_div.sv -----
// Restoring long divider: floor(num * 2^62 / den), saturated to 64 bits.
// Depends on rcdt_pkg for the step count.
module rcdt_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic [63:0]  quot,
  output logic         done
);
  import rcdt_pkg::*;

  logic [127:0] num_r, den_r, rem;
  logic [63:0]  q;
  logic         over, busy;
  logic [7:0]   cnt;
  logic [128:0] shifted, diff;
  logic         ge;

  always_comb begin
    shifted = {rem, num_r[127]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_r <= num;
        den_r <= den;
        rem   <= 128'd0;
        q     <= 64'd0;
        over  <= 1'b0;
        cnt   <= 8'd0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[127:0] : shifted[127:0];
        q     <= {q[62:0], ge};
        over  <= over | q[63];
        num_r <= {num_r[126:0], 1'b0};
        cnt   <= cnt + 8'd1;
        if (cnt == DIV_STEPS - 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = over ? '1 : q;

endmodule

// ----- rtl/rcdt_dp.sv -----
// Datapath: fit state, configuration registers, shared multiplier, dividers.
// Depends on rcdt_pkg, rcdt_mul and rcdt_div.
module rcdt_dp (
  input  logic                clk,
  input  logic                rst,
  input  rcdt_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  rcdt_pkg::dp_cmd_t   cmd,
  output rcdt_pkg::dp_stat_t  stat,
  output rcdt_pkg::out_item_t out_data
);
  import rcdt_pkg::*;

  // configuration
  logic [19:0] rate;
  logic [31:0] forget, warmup, reanchor, max_lag;

  // fit state
  logic [31:0] expected_count, anchor_count;
  logic [63:0] period_est, covariance, period_committed, anchor_time;

  // per-packet working registers
  logic [63:0]  arr, ymag, xx, gain, emag, r5, pred;
  logic [31:0]  x, lost;
  logic         warm, yneg, eneg, need_chk;
  logic [127:0] den, numg, bq, diff;
  logic [1:0]   fit;

  // load-cycle logic
  logic [31:0] nxt, exp_new, lost_new, x_new;
  logic [63:0] yu;
  logic        warm_new;

  // multiplier
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         mul_done;

  // capture logic
  logic [127:0] ye, e, anc_sum, p_sum;
  logic         e_neg;
  logic [63:0]  delta, pe_upd, gq, cq, lam;
  logic         div_done_g, div_done_c;

  always_comb begin
    nxt = expected_count + 32'd1;
    if (in_data.packet_count_rel > nxt) begin
      lost_new = in_data.packet_count_rel - expected_count - 32'd1;
      exp_new  = in_data.packet_count_rel;
    end else begin
      lost_new = 32'd0;
      exp_new  = nxt;
    end
    x_new    = exp_new - anchor_count;
    warm_new = exp_new < warmup;
    yu       = {in_data.arrival_us[47:0], 16'd0} - anchor_time;
  end

  always_comb begin
    lam = warm ? ONE_Q62 : {2'd0, forget, 30'd0};
    case (cmd.op)
      OP_XX:    begin mul_a = {32'd0, x};    mul_b = {32'd0, x};    end
      OP_DEN:   begin mul_a = xx;            mul_b = covariance;    end
      OP_NUMG:  begin mul_a = covariance;    mul_b = {32'd0, x};    end
      OP_TX:    begin mul_a = period_est;    mul_b = {32'd0, x};    end
      OP_DELTA: begin mul_a = emag;          mul_b = gain;          end
      OP_R5:    begin mul_a = {44'd0, rate}; mul_b = SCALE_1E5;     end
      OP_B:     begin mul_a = period_est;    mul_b = {44'd0, rate}; end
      OP_C:     begin mul_a = period_est;    mul_b = r5;            end
      OP_ANC:   begin mul_a = {32'd0, x};    mul_b = period_est;    end
      OP_PRED:  begin mul_a = {32'd0, x};    mul_b = period_committed; end
      default:  begin mul_a = 64'd0;         mul_b = 64'd0;         end
    endcase
  end

  rcdt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  rcdt_div u_div_gain (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (numg),
    .den   (den),
    .quot  (gq),
    .done  (div_done_g)
  );

  rcdt_div u_div_cov (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   ({64'd0, covariance}),
    .den   (den),
    .quot  (cq),
    .done  (div_done_c)
  );

  always_comb begin
    // residual against the product just finished (period_est * x)
    ye = {40'd0, ymag, 24'd0};
    if (yneg) begin
      e = ye + prod; e_neg = 1'b1;
    end else if (ye >= prod) begin
      e = ye - prod; e_neg = 1'b0;
    end else begin
      e = prod - ye; e_neg = 1'b1;
    end
    delta = (|prod[127:126]) ? '1 : prod[125:62];
    if (eneg) pe_upd = (delta > period_est) ? 64'd0 : period_est - delta;
    else      pe_upd = (delta > ~period_est) ? '1 : period_est + delta;
    anc_sum = prod + RND_Q16;
    p_sum   = {40'd0, anchor_time, 24'd0} + prod + RND_US;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate             <= RST_RATE;
      forget           <= RST_FORGET;
      warmup           <= RST_WARMUP;
      reanchor         <= RST_REANCHOR;
      max_lag          <= RST_MAX_LAG;
      expected_count   <= 32'd0;
      anchor_count     <= 32'd0;
      period_est       <= {4'd0, RST_PERIOD};
      period_committed <= {4'd0, RST_PERIOD};
      covariance       <= ONE_Q62;
      anchor_time      <= {RST_START[47:0], 16'd0};
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RATE:     rate <= cfg_data[19:0];
          CFG_PERIOD: begin
            period_est       <= {4'd0, cfg_data[59:0]};
            period_committed <= {4'd0, cfg_data[59:0]};
          end
          CFG_FORGET:   forget   <= cfg_data[31:0];
          CFG_WARMUP:   warmup   <= cfg_data[31:0];
          CFG_REANCHOR: reanchor <= cfg_data[31:0];
          CFG_START:    anchor_time <= {cfg_data[47:0], 16'd0};
          CFG_MAX_LAG:  max_lag  <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        expected_count <= exp_new;
        lost           <= lost_new;
        x              <= x_new;
        warm           <= warm_new;
        need_chk       <= !warm_new && (x_new >= reanchor);
        fit            <= warm_new ? FIT_WARM : FIT_ACC;
        arr            <= in_data.arrival_us;
        yneg           <= yu[63];
        ymag           <= yu[63] ? (64'd0 - yu) : yu;
      end
      if (cmd.mul_cap) begin
        case (cmd.op)
          OP_XX:    xx <= prod[63:0];
          OP_DEN:   den <= prod + {64'd0, lam};
          OP_NUMG:  numg <= prod;
          OP_TX: begin
            emag <= (|e[127:64]) ? '1 : e[63:0];
            eneg <= e_neg;
          end
          OP_DELTA: period_est <= pe_upd;
          OP_R5:    r5 <= prod[63:0];
          OP_B:     bq <= prod;
          OP_C:     diff <= (PLAUS_A >= prod) ? PLAUS_A - prod : prod - PLAUS_A;
          OP_ANC: begin
            anchor_time      <= anchor_time + anc_sum[87:24];
            period_committed <= period_est;
            anchor_count     <= expected_count;
            x                <= 32'd0;
            fit              <= FIT_COMMIT;
          end
          OP_PRED:  pred <= p_sum[103:40];
          default: ;
        endcase
      end
      if (cmd.div_cap) begin
        if (den == 128'd0) begin
          gain       <= 64'd0;
          covariance <= '1;
        end else begin
          gain       <= gq;
          covariance <= cq;
        end
      end
      if (cmd.reject) fit <= FIT_REJECT;
      if (cmd.stamp) begin
        out_data.lost_packets <= lost;
        out_data.fit_status   <= fit;
        if (pred > arr) begin
          out_data.stamp_us   <= arr;
          out_data.clamp_kind <= CLAMP_ARR;
        end else if (arr - pred > {32'd0, max_lag}) begin
          out_data.stamp_us   <= arr - {32'd0, max_lag};
          out_data.clamp_kind <= CLAMP_LAG;
        end else begin
          out_data.stamp_us   <= pred;
          out_data.clamp_kind <= CLAMP_NONE;
        end
      end
    end
  end

  always_comb begin
    stat.mul_done = mul_done;
    stat.div_done = div_done_g & div_done_c;
    stat.need_chk = need_chk;
    stat.fit_ok   = diff < bq;
  end

endmodule

// ----- rtl/rcdt_ctrl.sv -----
// Sequencer: walks one packet through the products, the divide and the stamp.
// Depends on rcdt_pkg for the command and status structs.
module rcdt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rcdt_pkg::dp_cmd_t  cmd,
  input  rcdt_pkg::dp_stat_t stat
);
  import rcdt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_CHK, S_STAMP} state_t;

  state_t  state;
  mul_op_t op;
  logic    mul_go, div_go;
  logic    mul_go_next, div_go_next;
  logic    out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load    = in_valid && (state == S_IDLE);
    cmd.mul_go  = mul_go;
    cmd.op      = op;
    cmd.mul_cap = (state == S_MUL) && stat.mul_done;
    cmd.div_go  = div_go;
    cmd.div_cap = (state == S_DIV) && stat.div_done;
    cmd.reject  = (state == S_CHK) && !stat.fit_ok;
    cmd.stamp   = (state == S_STAMP) && out_free;
  end

  // next product or divide to launch
  always_comb begin
    mul_go_next = 1'b0;
    div_go_next = 1'b0;
    unique case (state)
      S_IDLE: mul_go_next = in_valid;
      S_MUL: begin
        if (stat.mul_done) begin
          unique case (op) inside
            OP_XX, OP_DEN, OP_NUMG, OP_DELTA, OP_R5, OP_B, OP_ANC: mul_go_next = 1'b1;
            OP_TX:   div_go_next = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV:   mul_go_next = stat.div_done;
      S_CHK:   mul_go_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_XX;
      mul_go    <= 1'b0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_go <= mul_go_next;
      div_go <= div_go_next;
      if ((state == S_STAMP) && out_free) out_valid <= 1'b1;
      else if (out_ready)                 out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
            op    <= OP_XX;
          end
        end
        S_MUL: begin
          if (stat.mul_done) begin
            unique case (op)
              OP_XX:   op <= OP_DEN;
              OP_DEN:  op <= OP_NUMG;
              OP_NUMG: op <= OP_TX;
              OP_TX:   state <= S_DIV;
              OP_DELTA: begin
                if (stat.need_chk) begin
                  op <= OP_R5;
                end else begin
                  op <= OP_PRED;
                end
              end
              OP_R5:   op <= OP_B;
              OP_B:    op <= OP_C;
              OP_C:    state <= S_CHK;
              OP_ANC:  op <= OP_PRED;
              OP_PRED: state <= S_STAMP;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_MUL;
            op    <= OP_DELTA;
          end
        end
        S_CHK: begin
          state <= S_MUL;
          op    <= stat.fit_ok ? OP_ANC : OP_PRED;
        end
        S_STAMP: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rls_clock_drift_timestamper.sv -----
// Packet timestamper with a recursive least squares fit of the sample period.
// Top level: joins rcdt_ctrl and rcdt_dp; types come from rcdt_pkg.
//
//   channel | direction | handshake         | beat
//   --------+-----------+-------------------+-------------------------------------
//   in      | to block  | in_valid/in_ready | one packet: counter, arrival time
//   out     | from block| out_valid/out_ready| one stamp, lost count, clamp, fit
//   cfg     | to block  | cfg_we            | one register write, index + data
//
// Each packet passes the 190-step long divider (gain and covariance in
// parallel) and 6 to 10 products on one 32x32 multiplier.
// Reset is synchronous and loads the register defaults and the fit state.
// A finished beat waits in the output register; the next packet is taken
// meanwhile and only the stamp step stalls until the output slot frees.
module rls_clock_drift_timestamper (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcdt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcdt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import rcdt_pkg::*;

  dp_cmd_t  cmd;   // sequencer to datapath
  dp_stat_t stat;  // datapath to sequencer

  rcdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath holds config, fit state and the output beat register.
  rcdt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/rcdt_chk.sv -----
// Port-level checks for the timestamper, bound to the top level.
// Depends on rcdt_pkg for the payload types and clamp codes.
module rcdt_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input rcdt_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rcdt_pkg::out_item_t out_data
);
  import rcdt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second packet taken while one is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared the cycle after a packet was taken");

  a_clamp_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.clamp_kind == CLAMP_NONE ||
                  out_data.clamp_kind == CLAMP_ARR ||
                  out_data.clamp_kind == CLAMP_LAG)
    else $error("undefined clamp code on output");

endmodule

bind rls_clock_drift_timestamper rcdt_chk u_chk (.*);
